>>> rtl/assert_macros.svh
// Assertion macros used by the tier select top level.
// Each macro expects i_clk and i_rst_n to be visible in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock outside reset.
`define ATSEL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tier select assertion failed");

// Condition in one cycle implies a consequence in the next.
`define ATSEL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tier select assertion failed");

`endif

>>> rtl/atsel_pkg.sv
// Shared types and constants of the adaptive resolution tier select block.
// No dependencies; every RTL module imports this package.
package atsel_pkg;

    localparam int unsigned LVL_W     = 16;
    localparam int unsigned HYST_W    = 14;
    localparam int unsigned DIM_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned PROD_W    = 2 * DIM_W;

    // Q1.15 constants
    localparam logic [LVL_W-1:0]  FULL_Q15  = 16'd32768;
    localparam logic [LVL_W-1:0]  MIN_SCALE = 16'd1;
    localparam logic [HYST_W-1:0] MAX_HYST  = 14'd8192;
    localparam logic [PROD_W:0]   ROUND_Q15 = 33'd16384;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        TIER_NATIVE  = 2'd0,
        TIER_QUALITY = 2'd1,
        TIER_HALF    = 2'd2
    } t_tier;

    typedef enum logic [1:0] {
        RSN_FIXED  = 2'd0,
        RSN_LOW    = 2'd1,
        RSN_HIGH   = 2'd2,
        RSN_INSIDE = 2'd3
    } t_reason;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE        = 3'd0,
        CFG_QUALITY_ENTER = 3'd1,
        CFG_HALF_ENTER    = 3'd2,
        CFG_HYSTERESIS    = 3'd3,
        CFG_SCALE_LIMIT   = 3'd4,
        CFG_QUALITY_SCALE = 3'd5,
        CFG_HALF_SCALE    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic              enable;
        logic [LVL_W-1:0]  quality_enter;
        logic [LVL_W-1:0]  half_enter;
        logic [HYST_W-1:0] hysteresis;
        logic [LVL_W-1:0]  scale_limit;
        logic [LVL_W-1:0]  quality_scale;
        logic [LVL_W-1:0]  half_scale;
    } t_cfg;

    // Decided request waiting for the extent computation
    typedef struct packed {
        t_tier            tier;
        t_reason          reason;
        logic [LVL_W-1:0] eff;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             first;
    } t_job;

    typedef struct packed {
        t_tier            tier;
        t_reason          reason;
        logic [LVL_W-1:0] eff;
        logic [DIM_W-1:0] act_width;
        logic [DIM_W-1:0] act_height;
        logic             changed;
    } t_result;

endpackage

>>> rtl/atsel_cfg.sv
// Configuration register file of the tier select block.
// Depends on atsel_pkg.
module atsel_cfg
    import atsel_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CFG_DAT_W-1:0] i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.quality_enter <= 16'd16384;
            r_cfg.half_enter    <= 16'd24576;
            r_cfg.hysteresis    <= 14'd1638;
            r_cfg.scale_limit   <= 16'd32768;
            r_cfg.quality_scale <= 16'd24576;
            r_cfg.half_scale    <= 16'd16384;
        end else if (i_wr) begin
            case (t_cfg_idx'(i_index))
                CFG_ENABLE:        r_cfg.enable        <= i_data[0];
                CFG_QUALITY_ENTER: r_cfg.quality_enter <= i_data;
                CFG_HALF_ENTER:    r_cfg.half_enter    <= i_data;
                CFG_HYSTERESIS:    r_cfg.hysteresis    <= i_data[HYST_W-1:0];
                CFG_SCALE_LIMIT:   r_cfg.scale_limit   <= i_data;
                CFG_QUALITY_SCALE: r_cfg.quality_scale <= i_data;
                CFG_HALF_SCALE:    r_cfg.half_scale    <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/atsel_front.sv
// Front end: accepts requests, picks tier, reason and effective scale.
// Depends on atsel_pkg; feeds atsel_fifo.
module atsel_front
    import atsel_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [LVL_W-1:0] i_coverage,
    input  logic             i_inside,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    input  logic             i_full,
    output logic             o_push,
    output t_job             o_job
);

    logic  r_has_decided;
    t_tier r_last_tier;

    function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_W-1:0] v);
        return (v > FULL_Q15) ? FULL_Q15 : v;
    endfunction

    function automatic logic [LVL_W-1:0] sat_scale(input logic [LVL_W-1:0] v);
        logic [LVL_W-1:0] s;
        s = (v > FULL_Q15) ? FULL_Q15 : v;
        return (s < MIN_SCALE) ? MIN_SCALE : s;
    endfunction

    logic [LVL_W-1:0]  cov, q_enter, h_enter, q_exit, h_exit, h_exit_raw;
    logic [LVL_W-1:0]  hyst, t_scale, limit;
    t_tier             prev, tier;
    t_reason           reason;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Thresholds with saturation and hysteresis
    always_comb begin
        cov        = sat_level(i_coverage);
        q_enter    = sat_level(i_cfg.quality_enter);
        h_enter    = sat_level(i_cfg.half_enter);
        if (h_enter < q_enter) h_enter = q_enter;
        hyst       = (i_cfg.hysteresis > MAX_HYST) ? LVL_W'(MAX_HYST)
                                                   : LVL_W'(i_cfg.hysteresis);
        q_exit     = (q_enter > hyst) ? (q_enter - hyst) : '0;
        h_exit_raw = (h_enter > hyst) ? (h_enter - hyst) : '0;
        h_exit     = (h_exit_raw < q_exit) ? q_exit : h_exit_raw;
    end

    // Tier decision from the previous tier
    always_comb begin
        prev   = r_has_decided ? r_last_tier : TIER_NATIVE;
        tier   = TIER_NATIVE;
        reason = RSN_FIXED;
        if (i_cfg.enable) begin
            if (i_inside) begin
                tier = TIER_HALF;
            end else begin
                case (prev)
                    TIER_QUALITY: begin
                        if (cov >= h_enter)     tier = TIER_HALF;
                        else if (cov < q_exit)  tier = TIER_NATIVE;
                        else                    tier = TIER_QUALITY;
                    end
                    TIER_HALF: begin
                        if (cov < q_exit)       tier = TIER_NATIVE;
                        else if (cov < h_exit)  tier = TIER_QUALITY;
                        else                    tier = TIER_HALF;
                    end
                    default: begin
                        if (cov >= h_enter)     tier = TIER_HALF;
                        else if (cov >= q_enter) tier = TIER_QUALITY;
                        else                    tier = TIER_NATIVE;
                    end
                endcase
            end
            if (i_inside)                 reason = RSN_INSIDE;
            else if (tier != TIER_NATIVE) reason = RSN_HIGH;
            else                          reason = RSN_LOW;
        end
    end

    // Effective scale: min of limit and tier scale
    always_comb begin
        case (tier)
            TIER_QUALITY: t_scale = sat_scale(i_cfg.quality_scale);
            TIER_HALF:    t_scale = sat_scale(i_cfg.half_scale);
            default:      t_scale = FULL_Q15;
        endcase
        limit = sat_scale(i_cfg.scale_limit);
    end

    always_comb begin
        o_job.tier   = tier;
        o_job.reason = reason;
        o_job.eff    = (limit < t_scale) ? limit : t_scale;
        o_job.width  = i_width;
        o_job.height = i_height;
        o_job.first  = !r_has_decided;
    end

    // Decision history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_decided <= 1'b0;
            r_last_tier   <= TIER_NATIVE;
        end else if (o_push) begin
            r_has_decided <= 1'b1;
            r_last_tier   <= tier;
        end
    end

endmodule

>>> rtl/atsel_fifo.sv
// Short queue of decided requests between front and back end.
// Depends on atsel_pkg for the entry type.
module atsel_fifo
    import atsel_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wptr] <= i_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            if (rd_en) r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            if (wr_en && !rd_en)      r_count <= r_count + 1'b1;
            else if (rd_en && !wr_en) r_count <= r_count - 1'b1;
        end
    end

endmodule

>>> rtl/atsel_back.sv
// Back end: scales the extent, rounds, clamps and flags extent changes.
// Depends on atsel_pkg; drains atsel_fifo, drives the output register.
module atsel_back
    import atsel_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic              r_s1_v, r_o_v;
    t_job              r_s1_job;
    logic [PROD_W-1:0] r_prod_w, r_prod_h;
    logic [DIM_W-1:0]  r_last_w, r_last_h;
    t_result           r_res, n_res;
    logic              out_ld, s1_ld, empty_scene;
    logic [DIM_W-1:0]  aw, ah;

    // Round half up, clamp to 1..dim
    function automatic logic [DIM_W-1:0] round_clamp(input logic [PROD_W-1:0] prod,
                                                     input logic [DIM_W-1:0]  dim);
        logic [PROD_W:0]   sum;
        logic [PROD_W-15:0] r;
        sum = {1'b0, prod} + ROUND_Q15;
        r   = sum[PROD_W:15];
        if (r == '0) r = (PROD_W-14)'(1);
        if (r > (PROD_W-14)'(dim)) r = (PROD_W-14)'(dim);
        return r[DIM_W-1:0];
    endfunction

    // Pipeline advance
    assign out_ld = r_s1_v && (!r_o_v || i_ready);
    assign s1_ld  = !r_s1_v || out_ld;
    assign o_pop  = s1_ld && !i_empty;

    // Stage 1: the two products
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_job <= i_job;
            r_prod_w <= i_job.width * i_job.eff;
            r_prod_h <= i_job.height * i_job.eff;
        end
    end

    // Stage 2: round, clamp, compare with last extent
    always_comb begin
        empty_scene = (r_s1_job.width == '0) || (r_s1_job.height == '0);
        aw = empty_scene ? '0 : round_clamp(r_prod_w, r_s1_job.width);
        ah = empty_scene ? '0 : round_clamp(r_prod_h, r_s1_job.height);
        n_res.tier       = r_s1_job.tier;
        n_res.reason     = r_s1_job.reason;
        n_res.eff        = r_s1_job.eff;
        n_res.act_width  = aw;
        n_res.act_height = ah;
        n_res.changed    = r_s1_job.first || (aw != r_last_w) || (ah != r_last_h);
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) r_res <= n_res;
    end

    // Valid flags and last extent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_o_v    <= 1'b0;
            r_last_w <= '0;
            r_last_h <= '0;
        end else begin
            if (s1_ld) r_s1_v <= !i_empty;
            if (out_ld) begin
                r_o_v    <= 1'b1;
                r_last_w <= aw;
                r_last_h <= ah;
            end else if (i_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_v;
    assign o_res   = r_res;

endmodule

>>> rtl/adaptive_resolution_tier_select.sv
// Adaptive resolution tier select. Takes one request per clock: coverage,
// camera-inside flag and scene size in, tier, reason, effective scale, scaled
// extent and a change flag out. The front end decides the tier in the accept
// cycle and queues the decision; the back end does the two 16x16 multiplies
// in one stage and rounding, clamping and change detection in the next.
// A result passes through the decision queue, the stage-1 product registers
// and the output register, which holds it until it is taken.
// Throughput is one request per cycle; input ready drops only when the
// decision queue is full. Configuration writes are taken at any time, one
// per cycle, but belong in idle periods.
`include "assert_macros.svh"

module adaptive_resolution_tier_select
    import atsel_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tdata: coverage[15:0], scene_width[31:16], scene_height[47:32]
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [47:0]          i_s_axis_tdata,
    // tuser: camera_inside[0]
    input  logic                 i_s_axis_tuser,
    // tdata: tier[1:0], reason[3:2], effective_scale[19:4],
    //        active_width[35:20], active_height[51:36], zero fill[55:52]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [55:0]          o_m_axis_tdata,
    // tuser: extent_changed[0]
    output logic                 o_m_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_job    push_job, pop_job;
    logic    push, pop, full, empty;
    t_result res;

    assign o_cfg_ready = 1'b1;

    atsel_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    atsel_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_coverage (i_s_axis_tdata[15:0]),
        .i_inside   (i_s_axis_tuser),
        .i_width    (i_s_axis_tdata[31:16]),
        .i_height   (i_s_axis_tdata[47:32]),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    atsel_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (pop_job),
        .o_full  (full),
        .o_empty (empty)
    );

    atsel_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (pop_job),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    // Output packing
    assign o_m_axis_tdata = {4'b0, res.act_height, res.act_width, res.eff,
                             res.reason, res.tier};
    assign o_m_axis_tuser = res.changed;

    // A non-native tier always carries a coverage or camera reason
    `ATSEL_ASSERT(a_tier_reason, !o_m_axis_tvalid || res.tier == TIER_NATIVE || res.reason == RSN_HIGH || res.reason == RSN_INSIDE)
    // Both extents are zero together or not at all
    `ATSEL_ASSERT(a_empty_pair, !o_m_axis_tvalid || ((res.act_width == '0) == (res.act_height == '0)))
    // Effective scale stays within 1..full
    `ATSEL_ASSERT(a_eff_range, !o_m_axis_tvalid || (res.eff != '0 && res.eff <= FULL_Q15))
    // A stalled result holds its value
    `ATSEL_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

endmodule
